// File: rtl/sha256_pkg.sv
// Package for the SHA-256 message hasher: payload structs, state encoding,
// initial hash values, round constants and the round functions. No dependencies.
`timescale 1ns / 1ps
package sha256_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PAD,
    ST_LEN,
    ST_HLOAD,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } sha_state_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic logic [31:0] iv_word(input logic [2:0] i);
    logic [31:0] r;
    begin
      unique case (i)
        3'd0: r = 32'h6a09e667;
        3'd1: r = 32'hbb67ae85;
        3'd2: r = 32'h3c6ef372;
        3'd3: r = 32'ha54ff53a;
        3'd4: r = 32'h510e527f;
        3'd5: r = 32'h9b05688c;
        3'd6: r = 32'h1f83d9ab;
        default: r = 32'h5be0cd19;
      endcase
      return r;
    end
  endfunction

  // Places a byte into its big-endian lane; lane zero starts a fresh word.
  function automatic logic [31:0] put_lane(input logic [31:0] w, input logic [1:0] lane,
                                           input logic [7:0] b);
    logic [31:0] r;
    begin
      unique case (lane)
        2'd0: r = {b, 24'd0};
        2'd1: r = {w[31:24], b, 16'd0};
        2'd2: r = {w[31:16], b, 8'd0};
        default: r = {w[31:8], b};
      endcase
      return r;
    end
  endfunction

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

endpackage

// File: rtl/sha256_message_hasher_unit.sv
// Top level of the SHA-256 message hasher: byte packing, padding, round engine
// and digest output. Depends on sha256_pkg.
`timescale 1ns / 1ps
// A message byte is taken while the unit is loading; the 64th byte of a block
// starts a compression (loading the working variables from the chaining-value
// memory, 64 rounds, adding them back), during which no request is taken. The
// chaining value and the block words live in synchronous memories read in the
// cycle before their use; the sixteen-word schedule window is kept in registers.
// A last request then writes the 0x80 byte and each remaining zero or length
// word, runs a second compression when the length no longer fits, and delivers
// eight digest words, most significant first; a word waits while the previous
// one is held with out_ready low.
module sha256_message_hasher_unit
  import sha256_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  sha_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output sha_out_t out_data
);

  logic [31:0] wmem [16];
  logic [31:0] hmem [8];
  logic [7:0]  hvalid_r, hvalid_nxt;

  sha_state_t  state_r, state_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [63:0] len_r, len_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        fin_r, fin_nxt;
  logic        pad2_r, pad2_nxt;
  logic        lenblk_r, lenblk_nxt;
  logic [31:0] word_r, word_nxt;
  logic [31:0] a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt, e_nxt, f_nxt, g_nxt, h_nxt;
  logic [2:0]  oidx_r, oidx_nxt;
  logic        ovalid_r, ovalid_nxt;
  sha_out_t    obuf_r, obuf_nxt;

  logic        w_we, h_we;
  logic [3:0]  w_waddr, w_raddr;
  logic [31:0] w_wdata, w_rdata_r;
  logic [2:0]  h_waddr, h_raddr, h_rsel_r;
  logic [31:0] h_wdata, h_rdata_r;
  logic [31:0] hval;

  logic [31:0] win_r [16];
  logic [31:0] wnext_r;
  logic [31:0] wcur, t1, t2;

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_waddr] <= w_wdata;
    end
    w_rdata_r <= wmem[w_raddr];
    if (h_we) begin
      hmem[h_waddr] <= h_wdata;
    end
    h_rdata_r <= hmem[h_raddr];
    h_rsel_r <= h_raddr;
  end

  assign hval = hvalid_r[h_rsel_r] ? h_rdata_r : iv_word(h_rsel_r);

  // The window holds the last sixteen schedule words; the next word is formed
  // in the round before its use.
  always_ff @(posedge clk) begin
    if (state_r == ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i + 1];
      end
      win_r[15] <= wcur;
      wnext_r <= sig1(win_r[15]) + win_r[10] + sig0(win_r[2]) + win_r[1];
    end
  end

  assign wcur = (cnt_r < 7'd16) ? w_rdata_r : wnext_r;

  always_comb begin
    t1 = h_r + (ror(e_r, 6) ^ ror(e_r, 11) ^ ror(e_r, 25))
       + ((e_r & f_r) ^ (~e_r & g_r)) + ROUND_K[cnt_r[5:0]] + wcur;
    t2 = (ror(a_r, 2) ^ ror(a_r, 13) ^ ror(a_r, 22))
       + ((a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r));
  end

  always_comb begin
    state_nxt = state_r;
    pos_nxt = pos_r;
    len_nxt = len_r;
    cnt_nxt = cnt_r;
    fin_nxt = fin_r;
    pad2_nxt = pad2_r;
    lenblk_nxt = lenblk_r;
    word_nxt = word_r;
    oidx_nxt = oidx_r;
    ovalid_nxt = ovalid_r;
    obuf_nxt = obuf_r;
    hvalid_nxt = hvalid_r;
    {a_nxt, b_nxt, c_nxt, d_nxt, e_nxt, f_nxt, g_nxt, h_nxt} =
      {a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r};
    w_we = 1'b0;
    w_waddr = pos_r[5:2];
    w_wdata = 32'd0;
    w_raddr = 4'd0;
    h_we = 1'b0;
    h_waddr = 3'd0;
    h_wdata = 32'd0;
    h_raddr = 3'd0;
    in_ready = 1'b0;
    if (ovalid_r && out_ready) begin
      ovalid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_data.has_byte) begin
            len_nxt = len_r + 64'd8;
            word_nxt = put_lane(word_r, pos_r[1:0], in_data.data_byte);
            pos_nxt = pos_r + 6'd1;
            if (pos_r[1:0] == 2'd3) begin
              w_we = 1'b1;
              w_wdata = word_nxt;
            end
          end
          if (in_data.has_byte && pos_r == 6'd63) begin
            fin_nxt = in_data.last;
            state_nxt = ST_HLOAD;
            cnt_nxt = 7'd0;
          end else if (in_data.last) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        // Append 0x80 into the current word; the zero words and the length follow in ST_LEN.
        word_nxt = put_lane(word_r, pos_r[1:0], PAD_BYTE);
        w_we = 1'b1;
        w_wdata = word_nxt;
        pos_nxt = {pos_r[5:2] + 4'd1, 2'd0};
        fin_nxt = 1'b0;
        pad2_nxt = (pos_r[5:2] >= 4'd14);
        if (pos_r[5:2] == 4'd15) begin
          state_nxt = ST_HLOAD;
          cnt_nxt = 7'd0;
        end else begin
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        w_we = 1'b1;
        pos_nxt = pos_r + 6'd4;
        if (!pad2_r && pos_r[5:2] == 4'd14) begin
          w_wdata = len_r[63:32];
        end else if (!pad2_r && pos_r[5:2] == 4'd15) begin
          w_wdata = len_r[31:0];
        end
        if (pos_r[5:2] == 4'd15) begin
          lenblk_nxt = !pad2_r;
          state_nxt = ST_HLOAD;
          cnt_nxt = 7'd0;
        end
      end
      ST_HLOAD: begin
        h_raddr = cnt_r[2:0];
        if (cnt_r != 7'd0) begin
          {a_nxt, b_nxt, c_nxt, d_nxt, e_nxt, f_nxt, g_nxt, h_nxt} =
            {b_r, c_r, d_r, e_r, f_r, g_r, h_r, hval};
        end
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd8) begin
          w_raddr = 4'd0;
          state_nxt = ST_ROUND;
          cnt_nxt = 7'd0;
        end
      end
      ST_ROUND: begin
        h_nxt = g_r; g_nxt = f_r; f_nxt = e_r; e_nxt = d_r + t1;
        d_nxt = c_r; c_nxt = b_r; b_nxt = a_r; a_nxt = t1 + t2;
        w_raddr = cnt_r[3:0] + 4'd1;
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          state_nxt = ST_FINAL;
          cnt_nxt = 7'd0;
        end
      end
      ST_FINAL: begin
        h_raddr = cnt_r[2:0];
        if (cnt_r != 7'd0) begin
          h_we = 1'b1;
          h_waddr = cnt_r[2:0] - 3'd1;
          h_wdata = hval + a_r;
          hvalid_nxt[cnt_r[2:0] - 3'd1] = 1'b1;
          {a_nxt, b_nxt, c_nxt, d_nxt, e_nxt, f_nxt, g_nxt, h_nxt} =
            {b_r, c_r, d_r, e_r, f_r, g_r, h_r, a_r};
        end
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd8) begin
          cnt_nxt = 7'd0;
          if (lenblk_r) begin
            state_nxt = ST_EMIT;
            oidx_nxt = 3'd0;
          end else if (fin_r) begin
            state_nxt = ST_PAD;
          end else if (pad2_r) begin
            pad2_nxt = 1'b0;
            state_nxt = ST_LEN;
          end else begin
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_EMIT: begin
        h_raddr = oidx_r;
        if (cnt_r[0] == 1'b0) begin
          cnt_nxt = 7'd1;
        end else if (!ovalid_r || out_ready) begin
          ovalid_nxt = 1'b1;
          obuf_nxt.digest_word = hval;
          obuf_nxt.word_index = oidx_r;
          obuf_nxt.last_word = (oidx_r == 3'd7);
          oidx_nxt = oidx_r + 3'd1;
          cnt_nxt = 7'd0;
          if (oidx_r == 3'd7) begin
            state_nxt = ST_LOAD;
            hvalid_nxt = 8'd0;
            len_nxt = 64'd0;
            lenblk_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  assign out_valid = ovalid_r;
  assign out_data = obuf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      pos_r <= 6'd0;
      len_r <= 64'd0;
      cnt_r <= 7'd0;
      fin_r <= 1'b0;
      pad2_r <= 1'b0;
      lenblk_r <= 1'b0;
      oidx_r <= 3'd0;
      ovalid_r <= 1'b0;
      hvalid_r <= 8'd0;
    end else begin
      state_r <= state_nxt;
      pos_r <= pos_nxt;
      len_r <= len_nxt;
      cnt_r <= cnt_nxt;
      fin_r <= fin_nxt;
      pad2_r <= pad2_nxt;
      lenblk_r <= lenblk_nxt;
      oidx_r <= oidx_nxt;
      ovalid_r <= ovalid_nxt;
      hvalid_r <= hvalid_nxt;
    end
    word_r <= word_nxt;
    obuf_r <= obuf_nxt;
    {a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r} <=
      {a_nxt, b_nxt, c_nxt, d_nxt, e_nxt, f_nxt, g_nxt, h_nxt};
  end

`ifndef SYNTHESIS
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_LOAD) |-> !in_ready) else $error("request taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed");
  a_round_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && cnt_r == 7'd63) |=> (state_r == ST_FINAL))
    else $error("round count");
`endif

endmodule

// File: tb/tb.sv
// Self-checking testbench for the SHA-256 message hasher: streams message bytes,
// predicts each digest with its own SHA-256 model and compares every digest word.
// Depends on sha256_pkg and sha256_message_hasher_unit.
`timescale 1ns / 1ps
module tb
  import sha256_pkg::*;
();

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  sha_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  sha_out_t out_data;

  sha256_message_hasher_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  localparam logic [31:0] H0 [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
    32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  localparam logic [31:0] KTAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  logic [31:0] hash_state [8];
  logic [31:0] msg_block [16];
  logic [5:0]  byte_pos;
  logic [63:0] bit_len;
  sha_out_t    digest_q [$];

  int  errors;
  int  words_seen;
  int  messages;
  int  cycles;
  bit  quiet;

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++) w[i] = msg_block[i];
    for (int i = 16; i < 64; i++) begin
      w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    end
    {a, b, c, d, e, f, g, h} = {hash_state[0], hash_state[1], hash_state[2],
      hash_state[3], hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
    for (int i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + KTAB[i] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endtask

  task automatic absorb_byte(logic [7:0] v);
    logic [3:0] idx;
    idx = byte_pos[5:2];
    if (byte_pos[1:0] == 2'd0) msg_block[idx] = '0;
    msg_block[idx][8*(3 - byte_pos[1:0]) +: 8] = v;
    byte_pos = byte_pos + 6'd1;
    if (byte_pos == 6'd0) compress();
  endtask

  task automatic hash_request(sha_in_t r);
    sha_out_t o;
    if (r.has_byte) begin
      absorb_byte(r.data_byte);
      bit_len = bit_len + 64'd8;
    end
    if (!r.last) return;
    absorb_byte(PAD_BYTE);
    while (byte_pos != 6'd56) absorb_byte(8'h00);
    msg_block[14] = bit_len[63:32];
    msg_block[15] = bit_len[31:0];
    compress();
    for (int i = 0; i < 8; i++) begin
      o.digest_word = hash_state[i];
      o.word_index = 3'(i);
      o.last_word = (i == 7);
      digest_q.push_back(o);
    end
    hash_state = H0;
    byte_pos = '0;
    bit_len = '0;
    messages++;
  endtask

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_request(logic [7:0] v, logic has, logic fin);
    sha_in_t r;
    r.data_byte = v;
    r.has_byte = has;
    r.last = fin;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_data <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    hash_request(r);
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) send_request(8'($urandom), 1'b1, i == len - 1);
    if (len == 0) send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      words_seen++;
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest word, actual %h", $time, out_data);
        errors++;
      end else if (out_data !== digest_q[0]) begin
        $display("%0t: digest mismatch, expected %h/%0d/%0d actual %h/%0d/%0d", $time,
          digest_q[0].digest_word, digest_q[0].word_index, digest_q[0].last_word,
          out_data.digest_word, out_data.word_index, out_data.last_word);
        errors++;
        void'(digest_q.pop_front());
      end else begin
        void'(digest_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (quiet) out_ready <= 1'b1;
    else if ($urandom_range(0, 5) == 0) out_ready <= 1'b0;
    else out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic test_empty_message();
    send_request(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_field_extremes();
    send_request(8'hff, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b1);
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'h5a, 1'b0, 1'b0);
    send_request(8'ha5, 1'b1, 1'b0);
    send_request(8'h3c, 1'b0, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_block_boundaries();
    send_message(56);
    send_message(64);
  endtask

  task automatic test_random_messages();
    int n;
    n = 0;
    while (n < 80) begin
      int len;
      case ($urandom_range(0, 9))
        0: len = 0;
        1: len = $urandom_range(54, 66);
        default: len = $urandom_range(1, 12);
      endcase
      if ($urandom_range(0, 4) == 0) send_request(8'($urandom), 1'b0, 1'b0);
      send_message(len);
      n += (len == 0) ? 1 : len;
      if (n > 55) quiet = 1'b1;
    end
  endtask

  initial begin
    errors = 0;
    words_seen = 0;
    messages = 0;
    cycles = 0;
    quiet = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    hash_state = H0;
    byte_pos = '0;
    bit_len = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_message();
    test_field_extremes();
    test_block_boundaries();
    test_random_messages();
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Hashed %0d messages, checked %0d digest words.", messages, words_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
